/* rtl/core/bomr_pkg.sv */
// Shared types and constants of the box overlap match ranker.
// No dependencies; every other file of the block imports this package.
package bomr_pkg;

  localparam int MARGIN_W = 16;
  localparam int VOL_W    = 24;
  localparam int FRAC_W   = 17;
  localparam int RATIO_W  = 32;
  localparam int NUM_W    = 7;
  localparam int ENT_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  // Signed width of widened interval ends: 16-bit center plus half size plus margin.
  localparam int SW       = 19;
  // Divider: (a << FRAC_SHIFT) / b with a and b of DIV_W bits.
  localparam int DIV_W    = 24;
  localparam int FRAC_SHIFT = 16;
  localparam int DIV_Q_W  = DIV_W + FRAC_SHIFT;
  localparam int DIV_CNT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_AXIS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES    = 2'd2;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] SEL_X   = 2'd0;
  localparam logic [1:0] SEL_Y   = 2'd1;
  localparam logic [1:0] SEL_Z   = 2'd2;
  localparam logic [1:0] SEL_VOL = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [FRAC_W-1:0]  frac;
    logic [RATIO_W-1:0] ratio;
    logic               invalid;
  } hit_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic pop;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TEST,
    ST_DLOAD,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_INSERT
  } state_t;

endpackage

/* rtl/core/bomr_div.sv */
// Iterative restoring divider computing (a << 16) / b, one quotient bit per cycle.
// Depends on bomr_pkg for its widths.
module bomr_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bomr_pkg::DIV_W-1:0]     a,
  input  logic [bomr_pkg::DIV_W-1:0]     b,
  output logic                           done,
  output logic [bomr_pkg::DIV_Q_W-1:0]   q
);
  import bomr_pkg::*;

  logic [DIV_Q_W-1:0]   dvd_r, dvd_nxt;
  logic [DIV_W:0]       rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W+1:0]     trial;
  logic                 fits;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem_r, dvd_r[DIV_Q_W-1]};
  assign fits  = trial >= {2'b00, b};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      dvd_nxt  = {a, {FRAC_SHIFT{1'b0}}};
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_Q_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (DIV_W+1)'(trial - {2'b00, b}) : trial[DIV_W:0];
      dvd_nxt = {dvd_r[DIV_Q_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign q    = dvd_r;

endmodule

/* rtl/core/bomr_cell.sv */
// One cell of the sorted hit chain: holds one hit, inserts or shifts with its neighbors.
// Depends on bomr_pkg for the hit and control types.
module bomr_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bomr_pkg::cell_ctl_t   ctl,
  input  bomr_pkg::hit_t        new_hit,
  input  logic                  up_take,
  input  bomr_pkg::hit_t        up_hit,
  input  logic                  up_valid,
  input  bomr_pkg::hit_t        dn_hit,
  input  logic                  dn_valid,
  output bomr_pkg::hit_t        hit,
  output logic                  valid,
  output logic                  take
);
  import bomr_pkg::*;

  hit_t hit_r, hit_nxt;
  logic valid_r, valid_nxt;

  // A strictly larger overlap goes ahead of this cell; equal ones stay behind it.
  assign take = !valid_r || (new_hit.frac > hit_r.frac);

  always_comb begin
    hit_nxt   = hit_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins) begin
      if (up_take) begin
        hit_nxt   = up_hit;
        valid_nxt = up_valid;
      end else if (take) begin
        hit_nxt   = new_hit;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop) begin
      hit_nxt   = dn_hit;
      valid_nxt = dn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    hit_r <= hit_nxt;
  end

  assign hit   = hit_r;
  assign valid = valid_r;

endmodule

/* rtl/core/box_overlap_match_ranker.sv */
// Box overlap match ranker: a stored box table searched by query boxes, hits ranked.
// A store word is written as it is accepted. A query reads and tests each entry; a hit
// entry adds four 40-step divisions in one shared divider, two multiplies and an insert
// into the cell chain. Results then go out one word per cycle while the output is ready.
// Reset (synchronous, rst_n low) clears control state and configuration registers to their
// defaults; table contents stay undefined until written. Needs bomr_pkg, bomr_div, bomr_cell.
module box_overlap_match_ranker #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [5:0]                          in_slot,
  input  logic [15:0]                         in_center_x,
  input  logic [15:0]                         in_center_y,
  input  logic [15:0]                         in_center_z,
  input  logic [15:0]                         in_size_x,
  input  logic [15:0]                         in_size_y,
  input  logic [15:0]                         in_size_z,
  input  logic [23:0]                         in_volume,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [6:0]                          out_match_number,
  output logic [16:0]                         out_overlap_fraction,
  output logic [31:0]                         out_volume_ratio,
  output logic                                out_ratio_invalid,
  output logic                                out_size_zero,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [bomr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bomr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bomr_pkg::*;

  // Coordinates are masked to COORD_BITS, capped at the width of the 16-bit ports.
  localparam int CB = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic [MARGIN_W-1:0] margin_r;
  logic                depth_axis_r;
  logic [ENT_W-1:0]    entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r     <= '0;
      depth_axis_r <= 1'b1;
      entries_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MARGIN:     margin_r     <= cfg_wdata[MARGIN_W-1:0];
        CFG_DEPTH_AXIS: depth_axis_r <= cfg_wdata[0];
        CFG_ENTRIES:    entries_r    <= cfg_wdata[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word, masked.
  logic [CB-1:0] in_c [3];
  logic [CB-1:0] in_s [3];
  assign in_c[0] = in_center_x[CB-1:0];
  assign in_c[1] = in_center_y[CB-1:0];
  assign in_c[2] = in_center_z[CB-1:0];
  assign in_s[0] = in_size_x[CB-1:0];
  assign in_s[1] = in_size_y[CB-1:0];
  assign in_s[2] = in_size_z[CB-1:0];

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // Box table, one memory per field group, all written and read at the same address.
  logic [3*CB-1:0]  mem_cen [TABLE_DEPTH];
  logic [3*CB-1:0]  mem_siz [TABLE_DEPTH];
  logic [VOL_W-1:0] mem_vol [TABLE_DEPTH];
  logic [3*CB-1:0]  rd_cen_r;
  logic [3*CB-1:0]  rd_siz_r;
  logic [VOL_W-1:0] rd_vol_r;
  logic [NW-1:0]    idx_r, idx_nxt;
  logic             store_ok;

  // A store to a slot beyond the table is dropped.
  assign store_ok = 32'(in_slot) < TABLE_DEPTH;

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == KIND_STORE && store_ok) begin
      mem_cen[AW'(in_slot)] <= {in_c[2], in_c[1], in_c[0]};
      mem_siz[AW'(in_slot)] <= {in_s[2], in_s[1], in_s[0]};
      mem_vol[AW'(in_slot)] <= in_volume;
    end
    rd_cen_r <= mem_cen[idx_r[AW-1:0]];
    rd_siz_r <= mem_siz[idx_r[AW-1:0]];
    rd_vol_r <= mem_vol[idx_r[AW-1:0]];
  end

  // Query registers, captured when a query word is accepted.
  logic signed [SW-1:0] qmin_r [3];
  logic signed [SW-1:0] qmax_r [3];
  logic [CB-1:0]        qsize_r [3];
  logic [VOL_W-1:0]     qvol_r;
  logic                 zero_r;
  logic [NW-1:0]        limit_r;
  logic [NW-1:0]        limit_nxt;

  assign limit_nxt = (32'(entries_r) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(entries_r);

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == KIND_QUERY) begin
      for (int a = 0; a < 3; a++) begin
        qmin_r[a]  <= $signed({{(SW-CB){1'b0}}, in_c[a]})
                      - $signed({{(SW-CB+1){1'b0}}, in_s[a][CB-1:1]});
        qmax_r[a]  <= $signed({{(SW-CB){1'b0}}, in_c[a]})
                      + $signed({{(SW-CB+1){1'b0}}, in_s[a][CB-1:1]});
        qsize_r[a] <= in_s[a];
      end
      qvol_r  <= in_volume;
      zero_r  <= (in_s[0] == '0) || (in_s[1] == '0) || (depth_axis_r && in_s[2] == '0);
      limit_r <= limit_nxt;
    end
  end

  // Entry test: widen the stored box by the margin, apply the three-case interval
  // test on every axis, and form the overlap numerator (query size minus the parts
  // of the query side that stick out of the entry, floored at zero).
  logic signed [SW-1:0]  emin [3];
  logic signed [SW-1:0]  emax [3];
  logic signed [SW+1:0]  dsum [3];
  logic signed [SW+1:0]  nsub [3];
  logic [CB-1:0]         numer [3];
  logic                  ax_hit [3];
  logic                  ent_hit;
  logic signed [SW-1:0]  marg_s;

  assign marg_s = $signed({{(SW-MARGIN_W){1'b0}}, margin_r});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      emin[a] = $signed({{(SW-CB){1'b0}}, rd_cen_r[a*CB +: CB]})
                - $signed({{(SW-CB+1){1'b0}}, rd_siz_r[a*CB+1 +: CB-1]}) - marg_s;
      emax[a] = $signed({{(SW-CB){1'b0}}, rd_cen_r[a*CB +: CB]})
                + $signed({{(SW-CB+1){1'b0}}, rd_siz_r[a*CB+1 +: CB-1]}) + marg_s;
      ax_hit[a] = (emin[a] < qmax_r[a] && emin[a] >= qmin_r[a])
                  || (emax[a] > qmin_r[a] && emax[a] <= qmax_r[a])
                  || (emin[a] <= qmin_r[a] && emax[a] >= qmax_r[a]);
      dsum[a] = '0;
      if (emin[a] > qmin_r[a]) begin
        dsum[a] = dsum[a] + (SW+2)'(emin[a] - qmin_r[a]);
      end
      if (emax[a] < qmax_r[a]) begin
        dsum[a] = dsum[a] + (SW+2)'(qmax_r[a] - emax[a]);
      end
      nsub[a]  = $signed({{(SW+2-CB){1'b0}}, qsize_r[a]}) - dsum[a];
      numer[a] = (nsub[a] < 0) ? '0 : nsub[a][CB-1:0];
    end
    ent_hit = ax_hit[0] && ax_hit[1] && ax_hit[2];
  end

  // Shared divider: three axis fractions and then the volume ratio.
  logic [CB-1:0]      numer_r [3];
  logic [1:0]         sel_r, sel_nxt;
  logic               div_start;
  logic [DIV_W-1:0]   div_a;
  logic [DIV_W-1:0]   div_b;
  logic               div_done;
  logic [DIV_Q_W-1:0] div_q;

  always_comb begin
    case (sel_r)
      SEL_X: begin
        div_a = DIV_W'(numer_r[0]);
        div_b = DIV_W'(qsize_r[0]);
      end
      SEL_Y: begin
        div_a = DIV_W'(numer_r[1]);
        div_b = DIV_W'(qsize_r[1]);
      end
      SEL_Z: begin
        div_a = DIV_W'(numer_r[2]);
        div_b = DIV_W'(qsize_r[2]);
      end
      default: begin
        div_a = qvol_r;
        div_b = rd_vol_r;
      end
    endcase
  end

  bomr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  state_t              state_r, state_nxt;
  logic [FRAC_W-1:0]   frac_r [3];
  logic [RATIO_W-1:0]  ratio_r;
  logic                inv_r;
  logic [FRAC_W-1:0]   ov_r;
  logic [2*FRAC_W-1:0] prod;
  hit_t                new_hit_r;

  // Overlap multiply, one product per cycle, floored back to Q1.16.
  assign prod = (state_r == ST_MUL1) ? frac_r[0] * frac_r[1] : ov_r * frac_r[2];

  // Cell chain: the sorted hit list. Cell zero holds the largest overlap.
  cell_ctl_t ctl;
  hit_t      c_hit   [TABLE_DEPTH];
  logic      c_valid [TABLE_DEPTH];
  logic      c_take  [TABLE_DEPTH];
  hit_t      hit_none;

  assign hit_none = '0;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    bomr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_hit  (new_hit_r),
      .up_take  ((k == 0) ? 1'b0 : c_take[(k == 0) ? 0 : k-1]),
      .up_hit   ((k == 0) ? hit_none : c_hit[(k == 0) ? 0 : k-1]),
      .up_valid ((k == 0) ? 1'b0 : c_valid[(k == 0) ? 0 : k-1]),
      .dn_hit   ((k == TABLE_DEPTH-1) ? hit_none : c_hit[(k == TABLE_DEPTH-1) ? k : k+1]),
      .dn_valid ((k == TABLE_DEPTH-1) ? 1'b0 : c_valid[(k == TABLE_DEPTH-1) ? k : k+1]),
      .hit      (c_hit[k]),
      .valid    (c_valid[k]),
      .take     (c_take[k])
    );
  end

  // Sequencer.
  logic [NW-1:0] hits_r, hits_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_load;
  logic          out_last_nxt;
  logic          slot_free;
  logic          emit_r, emit_nxt;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    hits_nxt     = hits_r;
    sel_nxt      = sel_r;
    emit_nxt     = emit_r;
    div_start    = 1'b0;
    ctl          = '0;
    out_load     = 1'b0;
    out_last_nxt = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (emit_r) begin
          // Results go out of cell zero, one word per free output slot.
          if (slot_free) begin
            out_load = 1'b1;
            if (hits_r == '0) begin
              out_last_nxt = 1'b1;
              emit_nxt     = 1'b0;
            end else begin
              ctl.pop      = 1'b1;
              hits_nxt     = hits_r - 1'b1;
              out_last_nxt = (hits_r == NW'(1));
              emit_nxt     = (hits_r != NW'(1));
            end
          end
        end else begin
          in_ready = 1'b1;
          if (in_acc && in_kind == KIND_QUERY) begin
            ctl.clr  = 1'b1;
            idx_nxt  = '0;
            hits_nxt = '0;
            if (limit_nxt == '0) begin
              emit_nxt = 1'b1;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (ent_hit) begin
          sel_nxt   = SEL_X;
          state_nxt = ST_DLOAD;
        end else if (idx_r + 1'b1 == limit_r) begin
          emit_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_DLOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (sel_r == SEL_VOL) begin
            state_nxt = ST_MUL1;
          end else begin
            sel_nxt   = sel_r + 1'b1;
            state_nxt = ST_DLOAD;
          end
        end
      end
      ST_MUL1: begin
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        ctl.ins  = 1'b1;
        hits_nxt = hits_r + 1'b1;
        if (idx_r + 1'b1 == limit_r) begin
          emit_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      hits_r      <= '0;
      sel_r       <= SEL_X;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hits_r      <= hits_nxt;
      sel_r       <= sel_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers of the entry being processed.
  always_ff @(posedge clk) begin
    if (state_r == ST_TEST) begin
      for (int a = 0; a < 3; a++) begin
        numer_r[a] <= numer[a];
      end
    end
    if (state_r == ST_DIV && div_done) begin
      case (sel_r)
        SEL_X: frac_r[0] <= div_q[FRAC_W-1:0];
        SEL_Y: frac_r[1] <= div_q[FRAC_W-1:0];
        SEL_Z: frac_r[2] <= div_q[FRAC_W-1:0];
        default: begin
          // A zero entry volume flags the ratio; a quotient above 32 bits saturates.
          inv_r   <= (rd_vol_r == '0);
          ratio_r <= (rd_vol_r == '0 || div_q[DIV_Q_W-1:RATIO_W] != '0)
                     ? {RATIO_W{1'b1}} : div_q[RATIO_W-1:0];
        end
      endcase
    end
    if (state_r == ST_MUL1) begin
      ov_r <= prod[FRAC_SHIFT +: FRAC_W];
    end
    if (state_r == ST_MUL2) begin
      new_hit_r.num     <= NUM_W'(idx_r + 1'b1);
      new_hit_r.ratio   <= ratio_r;
      new_hit_r.invalid <= inv_r;
      if (zero_r) begin
        new_hit_r.frac <= '0;
      end else if (depth_axis_r) begin
        new_hit_r.frac <= prod[FRAC_SHIFT +: FRAC_W];
      end else begin
        new_hit_r.frac <= ov_r;
      end
    end
  end

  // Output register.
  logic                found_r;
  hit_t                out_hit_r;
  logic                size_zero_r;
  logic                last_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      found_r     <= (hits_r != '0);
      out_hit_r   <= (hits_r != '0) ? c_hit[0] : hit_none;
      size_zero_r <= (hits_r != '0) ? zero_r : 1'b0;
      last_r      <= out_last_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = found_r;
  assign out_match_number     = out_hit_r.num;
  assign out_overlap_fraction = out_hit_r.frac;
  assign out_volume_ratio     = out_hit_r.ratio;
  assign out_ratio_invalid    = out_hit_r.invalid;
  assign out_size_zero        = size_zero_r;
  assign out_last             = last_r;

endmodule
